@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the normal basis check.
// Uses clk and rst_n of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, off during reset.
`define GNB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle check, off during reset.
`define GNB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/gnb_pkg.sv @@
// Package for the Gaussian normal basis check: default widths and codes.
// No dependencies.
package gnb_pkg;

  localparam int unsigned DEGREE_BITS_DEF = 12;
  localparam int unsigned TYPE_BITS_DEF   = 8;

  // What the shared divider is working on.
  typedef enum logic [1:0] {
    PH_TRIAL = 2'd0,
    PH_QUOT  = 2'd1,
    PH_GCD   = 2'd2
  } phase_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SETUP  = 8'b0000_0010,
    S_BOUND  = 8'b0000_0100,
    S_TRIAL  = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_DIVEND = 8'b0010_0000,
    S_ORDER  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

endpackage

@@ sv/gaussian_normal_basis_check_core.sv @@
// Decides whether GF(2^m) has a type-t Gaussian normal basis. One word in, one word out;
// the core takes a new word only when idle and the result has been taken. With
// PW = DEGREE_BITS + TYPE_BITS and p = t*m + 1, a word passes through setup, then a
// trial division by each odd divisor (up to 2^(ceil(bits(p)/2) - 1) - 1 of them), then
// the order search (k steps, up to p - 1), then a division for t*m/k and one for each
// gcd step, then output, where the word stays while the result is stalled. A word refused
// at setup goes straight to output. A single restoring divider, one quotient bit per
// cycle, serves the trial division, the quotient and the gcd; the order search dominates
// at the default widths.
// Depends on gnb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gaussian_normal_basis_check_core
  import gnb_pkg::*;
#(
  parameter int unsigned DEGREE_BITS = DEGREE_BITS_DEF,
  parameter int unsigned TYPE_BITS   = TYPE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [DEGREE_BITS-1:0] in_degree,
  input  logic [TYPE_BITS-1:0]   in_basis_type,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_exists
);

  localparam int unsigned PW = DEGREE_BITS + TYPE_BITS;
  localparam int unsigned LW = $clog2(PW + 1);
  localparam int unsigned CW = $clog2(PW);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [DEGREE_BITS-1:0] m_r, m_nxt;
  logic [TYPE_BITS-1:0]   t_r, t_nxt;
  logic [PW-1:0]          tm_r, tm_nxt;
  logic [PW-1:0]          p_r, p_nxt;
  logic [PW-1:0]          bound_r, bound_nxt;
  logic [PW-1:0]          d_r, d_nxt;
  logic [PW-1:0]          u_r, u_nxt;
  logic [PW-1:0]          k_r, k_nxt;
  logic                   exists_r, exists_nxt;

  // shared divider
  logic [PW-1:0] n_r, n_nxt;    // dividend in, quotient out
  logic [PW-1:0] dv_r, dv_nxt;  // divisor
  logic [PW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [PW:0]   div_sh;
  logic [PW:0]   div_diff;
  logic [PW:0]   u_dbl;
  logic [PW:0]   u_red;
  logic [LW-1:0] p_len;
  logic [LW-1:0] half_len;
  logic [PW-1:0] tm_prod;
  logic          div_last;

  assign tm_prod  = PW'(t_r) * PW'(m_r);
  assign div_sh   = {rem_r, n_r[PW-1]};
  assign div_diff = div_sh - {1'b0, dv_r};
  assign u_dbl    = {u_r, 1'b0};
  assign u_red    = u_dbl - {1'b0, p_r};
  assign div_last = (state_r == S_DIV) && (cnt_r == CW'(PW - 1));

  always_comb begin
    p_len = '0;
    for (int i = 0; i < PW; i++) begin
      if (p_r[i]) begin
        p_len = LW'(i + 1);
      end
    end
  end

  // ceil(p_len / 2) without overflowing LW bits
  assign half_len = (p_len >> 1) + LW'(p_len[0]);

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    m_nxt      = m_r;
    t_nxt      = t_r;
    tm_nxt     = tm_r;
    p_nxt      = p_r;
    bound_nxt  = bound_r;
    d_nxt      = d_r;
    u_nxt      = u_r;
    k_nxt      = k_r;
    exists_nxt = exists_r;
    n_nxt      = n_r;
    dv_nxt     = dv_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          m_nxt     = in_degree;
          t_nxt     = in_basis_type;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        tm_nxt = tm_prod;
        p_nxt  = tm_prod + PW'(1);
        // multiple of 8, type zero, or even p: no basis
        if (m_r[2:0] == 3'd0 || t_r == '0 || tm_prod[0]) begin
          exists_nxt = 1'b0;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_BOUND;
        end
      end
      S_BOUND: begin
        bound_nxt = PW'(1) << half_len;
        d_nxt     = PW'(3);
        state_nxt = S_TRIAL;
      end
      S_TRIAL: begin
        if (d_r > bound_r) begin
          // p is prime; p >= 3 so 2 mod p is 2
          u_nxt     = PW'(2);
          k_nxt     = PW'(1);
          state_nxt = S_ORDER;
        end else begin
          n_nxt     = p_r;
          dv_nxt    = d_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_TRIAL;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_diff[PW]) begin
          rem_nxt = div_diff[PW-1:0];
          n_nxt   = {n_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh[PW-1:0];
          n_nxt   = {n_r[PW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(PW - 1)) begin
          state_nxt = S_DIVEND;
        end
      end
      S_DIVEND: begin
        unique case (phase_r)
          PH_TRIAL: begin
            if (rem_r == '0) begin
              exists_nxt = 1'b0;
              state_nxt  = S_OUT;
            end else begin
              d_nxt     = d_r + PW'(2);
              state_nxt = S_TRIAL;
            end
          end
          PH_QUOT: begin
            // gcd(h, m), h = t*m/k is never zero
            dv_nxt    = PW'(m_r);
            rem_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_GCD;
            state_nxt = S_DIV;
          end
          PH_GCD: begin
            if (rem_r == '0) begin
              exists_nxt = (dv_r == PW'(1));
              state_nxt  = S_OUT;
            end else begin
              n_nxt     = dv_r;
              dv_nxt    = rem_r;
              rem_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_ORDER: begin
        if (u_r == PW'(1)) begin
          n_nxt     = tm_r;
          dv_nxt    = k_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_QUOT;
          state_nxt = S_DIV;
        end else begin
          u_nxt = u_red[PW] ? u_dbl[PW-1:0] : u_red[PW-1:0];
          k_nxt = k_r + PW'(1);
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_TRIAL;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    t_r      <= t_nxt;
    tm_r     <= tm_nxt;
    p_r      <= p_nxt;
    bound_r  <= bound_nxt;
    d_r      <= d_nxt;
    u_r      <= u_nxt;
    k_r      <= k_nxt;
    exists_r <= exists_nxt;
    n_r      <= n_nxt;
    dv_r     <= dv_nxt;
    rem_r    <= rem_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign out_exists = exists_r;

  `GNB_ASSERT(a_out_blocks_in, out_valid |-> in_stall, "input taken while result pending")
  `GNB_ASSERT(a_div_nonzero, (state_r == S_DIV) |-> (dv_r != '0), "divide by zero")
  `GNB_ASSERT(a_order_range, (state_r == S_ORDER) |-> (u_r < p_r), "order residue out of range")
  `GNB_ASSERT(a_trial_odd, (state_r == S_TRIAL) |-> d_r[0], "even trial divisor")
  `GNB_ASSERT(a_yes_from_gcd, (out_valid && out_exists) |-> (phase_r == PH_GCD), "yes without gcd")
  `GNB_ASSERT_NEXT(a_div_len, div_last, state_r == S_DIVEND, "divider ran long")

endmodule

@@ tb/gaussian_normal_basis_check_core_tb.sv @@
// Testbench for gaussian_normal_basis_check_core: sends (degree, type) words, predicts
// whether a type-t Gaussian normal basis exists and checks each result word in order.
// Depends on gnb_pkg and the core RTL.
module gaussian_normal_basis_check_core_tb;
  import gnb_pkg::*;

  localparam int unsigned DW        = DEGREE_BITS_DEF;
  localparam int unsigned TW        = TYPE_BITS_DEF;
  localparam int unsigned MAX_GAP   = 13;
  localparam int unsigned LIMIT     = 10_000_000;
  localparam int unsigned COST_CAP  = 12_000;  // cycle budget for one full-range word
  localparam int unsigned N_RANDOM  = 64;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [DW-1:0] in_degree = '0;
  logic [TW-1:0] in_basis_type = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          out_exists;

  bit            tx_idle = 1'b0;
  bit            rx_idle = 1'b0;
  logic          rx_hold = 1'b0;
  int unsigned   rx_wait = 0;
  bit            exists_q[$];
  bit            exp_exists;
  int unsigned   mismatches = 0;
  int unsigned   cycles = 0;

  always #1 clk = ~clk;

  gaussian_normal_basis_check_core #(
    .DEGREE_BITS(DW),
    .TYPE_BITS  (TW)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_degree    (in_degree),
    .in_basis_type(in_basis_type),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_exists   (out_exists)
  );

  // Odd-only trial division up to 2^ceil(bits(n)/2).
  function automatic bit is_odd_prime(input int unsigned n);
    int unsigned len, bound, d, x;
    if (n[0] == 1'b0) return 1'b0;
    len = 0;
    for (x = n; x != 0; x = x >> 1) len++;
    bound = 1 << ((len + 1) / 2);
    for (d = 3; d <= bound; d += 2)
      if (n % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // Returns the expected exists bit; cost is a rough cycle estimate for the core.
  function automatic bit predict_exists(input logic [DW-1:0] m, input logic [TW-1:0] t,
                                        output int unsigned cost);
    int unsigned tm, p, k, u, h, a, b, r, len;
    cost = 8;
    if (m % 8 == 0 || t == 0) return 1'b0;
    tm = t * m;
    p = tm + 1;
    len = 0;
    for (u = p; u != 0; u = u >> 1) len++;
    cost = 600 + 11 * (1 << ((len + 1) / 2));
    if (!is_odd_prime(p)) return 1'b0;
    k = 1;
    u = 2 % p;
    while (u != 1) begin
      u = (u * 2) % p;
      k++;
    end
    cost += k;
    h = tm / k;
    a = h;
    b = m;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a == 1;
  endfunction

  // Small degree and type; most draws give a prime p so the order search runs.
  task automatic draw_small(output logic [DW-1:0] m, output logic [TW-1:0] t);
    bit want_prime;
    int unsigned tries;
    want_prime = $urandom_range(0, 9) < 7;
    for (tries = 0; tries < 64; tries++) begin
      m = DW'($urandom_range(1, 80));
      t = TW'($urandom_range(0, 15));
      if (!want_prime || (m % 8 != 0 && t != 0 && is_odd_prime(t * m + 1))) break;
    end
  endtask

  task automatic send_word(input logic [DW-1:0] m, input logic [TW-1:0] t);
    int unsigned gap, cost;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_degree     <= m;
    in_basis_type <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exists_q.push_back(predict_exists(m, t, cost));
  endtask

  task automatic wait_drained;
    @(negedge clk);
    in_valid <= 1'b0;
    while (exists_q.size() != 0) @(posedge clk);
  endtask

  task automatic hold_results(input int unsigned n);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (n) @(negedge clk);
    rx_hold <= 1'b0;
  endtask

  // Zero fields, multiples of 8, p even, small and known-good cases, all-ones fields.
  task automatic test_directed;
    int unsigned degs[]  = '{0, 0, 7, 1, 8, 4088, 4095, 4095, 1, 2, 4, 3, 5, 11, 7,
                             6, 163, 233, 283, 409, 571, 4092};
    int unsigned types[] = '{5, 0, 0, 1, 3, 255, 255, 1, 2, 1, 1, 2, 2, 2, 4,
                             1, 4, 2, 6, 4, 10, 1};
    int i;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (i = 0; i < degs.size(); i++) send_word(DW'(degs[i]), TW'(types[i]));
    wait_drained();
  endtask

  // Receiver holds off long enough for a result to sit and the input to stall.
  task automatic test_backpressure;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    fork
      hold_results(400);
    join_none
    send_word(5, 2);
    send_word(3, 2);
    send_word(11, 2);
    send_word(6, 1);
    send_word(7, 4);
    send_word(2, 1);
    wait_drained();
  endtask

  // Sender stops mid-stream until every result is back, then resumes.
  task automatic test_pause;
    logic [DW-1:0] m;
    logic [TW-1:0] t;
    int i;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (i = 0; i < 8; i++) begin
      if (i == 4) wait_drained();
      draw_small(m, t);
      send_word(m, t);
    end
    wait_drained();
  endtask

  task automatic test_random;
    logic [DW-1:0] m;
    logic [TW-1:0] t;
    int unsigned cost;
    bit dummy;
    int i;
    for (i = 0; i < N_RANDOM; i++) begin
      // every third block of 20 words runs with no idling on either side
      tx_idle = (i / 20) % 3 != 2;
      rx_idle = (i / 20) % 3 != 2;
      if ($urandom_range(0, 99) < 85) begin
        draw_small(m, t);
      end else begin
        // full-range word; redraw while the core would spend too long on it
        do begin
          m = DW'($urandom_range(0, (1 << DW) - 1));
          t = TW'($urandom_range(0, (1 << TW) - 1));
          dummy = predict_exists(m, t, cost);
        end while (cost > COST_CAP);
      end
      send_word(m, t);
    end
    wait_drained();
  endtask

  // Result check; rx_wait counts down only while a result word is offered.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exists_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result word: exists=%0b", out_exists);
        mismatches++;
      end else begin
        exp_exists = exists_q.pop_front();
        if (out_exists !== exp_exists) begin
          if (mismatches < 10)
            $display("exists mismatch: expected %0b, got %0b", exp_exists, out_exists);
          mismatches++;
        end
      end
      rx_wait <= rx_idle ? $urandom_range(0, MAX_GAP) : 0;
    end else if (out_valid && rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= rx_hold || (rx_wait != 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_pause();
    test_random();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && exists_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
